/* src/mls_pkg.sv */
package mls_pkg;

   localparam int CHANNELS = 2;
   localparam int LINE_MAX = 64;

   localparam int STORE_DEPTH = CHANNELS * LINE_MAX;
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Field widths are fixed by the interface.
   localparam int CH_W = 1;
   localparam int BYTE_W = 8;
   localparam int IDX_W = 6;
   localparam int LEN_W = 7;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]   out_channel;
      logic [BYTE_W-1:0] line_byte;
      logic [IDX_W-1:0]  byte_index;
      logic [LEN_W-1:0]  line_total;
      logic              last_byte;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wdata;
   } ram_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SHOW = 3'b100
   } state_type;

endpackage

/* src/mls_line_ram.sv */
module mls_line_ram #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/mls_framer.sv */
module mls_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mls_pkg::req_type      req_payload,
   output mls_pkg::ram_ctrl_type ram_ctrl,
   input  logic [7:0]            ram_rdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mls_pkg::rsp_type      rsp_payload
);

   import mls_pkg::*;

   state_type         state_ff, state_in;
   logic [CH_W-1:0]   emit_ch_ff, emit_ch_in;
   logic [LEN_W-1:0]  emit_len_ff, emit_len_in;
   logic [IDX_W-1:0]  emit_idx_ff, emit_idx_in;
   logic [LEN_W-1:0]  count_ff [CHANNELS];
   logic [LEN_W-1:0]  count_in [CHANNELS];
   logic              collect_ff [CHANNELS];
   logic              collect_in [CHANNELS];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              ch_ok;
   logic              is_eol;
   logic [LEN_W-1:0]  cur_count;
   logic              cur_collect;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              load;
   logic              last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign ch_ok     = (int'(req_payload.channel) < CHANNELS);
   assign is_eol    = (req_payload.data_byte == CHAR_CR) || (req_payload.data_byte == CHAR_LF);
   assign cur_count   = ch_ok ? count_ff[req_payload.channel] : '0;
   assign cur_collect = ch_ok ? collect_ff[req_payload.channel] : 1'b0;

   assign wr_addr = ADDR_W'(int'(req_payload.channel) * LINE_MAX + int'(cur_count));
   assign rd_addr = ADDR_W'(int'(emit_ch_ff) * LINE_MAX + int'(emit_idx_ff));

   // The output register takes a byte when it is empty or being drained.
   assign load = (state_ff == ST_SHOW) && (!rsp_valid_ff || !rsp_stall);
   assign last = ({1'b0, emit_idx_ff} + LEN_W'(1)) == emit_len_ff;

   always_comb begin
      state_in    = state_ff;
      emit_ch_in  = emit_ch_ff;
      emit_len_in = emit_len_ff;
      emit_idx_in = emit_idx_ff;
      count_in    = count_ff;
      collect_in  = collect_ff;
      ram_ctrl.wr_en = 1'b0;
      ram_ctrl.rd_en = 1'b0;
      ram_ctrl.addr  = rd_addr;
      ram_ctrl.wdata = req_payload.data_byte;

      case (state_ff)
         ST_IDLE: begin
            if (accept && ch_ok) begin
               if (is_eol) begin
                  if (cur_collect && (cur_count != '0)) begin
                     emit_ch_in  = req_payload.channel;
                     emit_len_in = cur_count;
                     emit_idx_in = '0;
                     state_in    = ST_READ;
                  end
                  count_in[req_payload.channel]   = '0;
                  collect_in[req_payload.channel] = 1'b1;
               end else if (cur_collect) begin
                  if (int'(cur_count) >= LINE_MAX) begin
                     // A full line is dropped and the channel waits for a line end.
                     count_in[req_payload.channel]   = '0;
                     collect_in[req_payload.channel] = 1'b0;
                  end else begin
                     ram_ctrl.wr_en = 1'b1;
                     ram_ctrl.addr  = wr_addr;
                     count_in[req_payload.channel] = cur_count + LEN_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            ram_ctrl.rd_en = 1'b1;
            state_in       = ST_SHOW;
         end
         ST_SHOW: begin
            if (load) begin
               emit_idx_in = emit_idx_ff + IDX_W'(1);
               state_in    = last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_channel = emit_ch_ff;
         rsp_data_in.line_byte   = ram_rdata;
         rsp_data_in.byte_index  = emit_idx_ff;
         rsp_data_in.line_total  = emit_len_ff;
         rsp_data_in.last_byte   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            count_ff[i]   <= '0;
            collect_ff[i] <= 1'b1;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         collect_ff   <= collect_in;
      end
      emit_ch_ff  <= emit_ch_in;
      emit_len_ff <= emit_len_in;
      emit_idx_ff <= emit_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* src/multichannel_line_splitter.sv */
// Ordinary bytes are taken one per cycle while no line is being emitted and, on a collecting
// channel with room, written straight into the line memory. A line end with a stored line
// stalls requests while the line is emitted: each byte is read from the memory in ST_READ and
// then loaded into the output register in ST_SHOW, which waits while the output is stalled.
// Reset empties every channel and sets it collecting; the line memory is not cleared.
module multichannel_line_splitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mls_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mls_pkg::rsp_type rsp_payload
);

   import mls_pkg::*;

   ram_ctrl_type      ram_ctrl;
   logic [BYTE_W-1:0] ram_rdata;

   mls_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .ram_ctrl    (ram_ctrl),
      .ram_rdata   (ram_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   mls_line_ram #(
      .DEPTH  (STORE_DEPTH),
      .WIDTH  (BYTE_W),
      .ADDR_W (ADDR_W)
   ) u_line_ram (
      .clock (clock),
      .wr_en (ram_ctrl.wr_en),
      .rd_en (ram_ctrl.rd_en),
      .addr  (ram_ctrl.addr),
      .wdata (ram_ctrl.wdata),
      .rdata (ram_rdata)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import mls_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   multichannel_line_splitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Requests waiting to be offered, and line bytes expected from the block.
   req_type pending_bytes [$];
   rsp_type expected_line_bytes [$];

   // Own copy of the per-channel line state.
   logic [BYTE_W-1:0] line_text [CHANNELS][LINE_MAX];
   int unsigned       line_fill [CHANNELS] = '{default: 0};
   bit                line_open [CHANNELS] = '{default: 1'b1};

   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   int  holds_asked = 0;
   int  holds_done = 0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;
   int  requests_queued = 0;
   int  requests_accepted = 0;
   int  bytes_checked = 0;
   int  lines_checked = 0;
   int  failures = 0;
   longint cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Works out the line bytes that one accepted request releases.
   function automatic void split_line_predict(req_type r);
      int unsigned ch;
      int unsigned len;
      rsp_type     line_byte_exp;
      ch = r.channel;
      if (ch >= CHANNELS) return;
      if (r.data_byte == CHAR_CR || r.data_byte == CHAR_LF) begin
         if (line_open[ch] && line_fill[ch] > 0) begin
            len = (line_fill[ch] > LINE_MAX) ? LINE_MAX : line_fill[ch];
            for (int i = 0; i < len; i++) begin
               line_byte_exp.out_channel = CH_W'(ch);
               line_byte_exp.line_byte   = line_text[ch][i];
               line_byte_exp.byte_index  = IDX_W'(i);
               line_byte_exp.line_total  = LEN_W'(len);
               line_byte_exp.last_byte   = (i + 1 == len);
               expected_line_bytes.push_back(line_byte_exp);
            end
         end
         line_fill[ch] = 0;
         line_open[ch] = 1'b1;
      end else if (line_open[ch]) begin
         if (line_fill[ch] >= LINE_MAX) begin
            // A byte on a full line throws the whole line away.
            line_fill[ch] = 0;
            line_open[ch] = 1'b0;
         end else begin
            line_text[ch][line_fill[ch]] = r.data_byte;
            line_fill[ch]++;
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            requests_accepted++;
            split_line_predict(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_line_bytes.size() == 0) begin
               $error("line byte %0h on channel %0d with nothing expected",
                      got.line_byte, got.out_channel);
               failures++;
            end else begin
               want = expected_line_bytes.pop_front();
               if (got.out_channel !== want.out_channel) begin
                  $error("out_channel: expected %0d, actual %0d",
                         want.out_channel, got.out_channel);
                  failures++;
               end
               if (got.line_byte !== want.line_byte) begin
                  $error("line_byte: expected %0h, actual %0h", want.line_byte, got.line_byte);
                  failures++;
               end
               if (got.byte_index !== want.byte_index) begin
                  $error("byte_index: expected %0d, actual %0d",
                         want.byte_index, got.byte_index);
                  failures++;
               end
               if (got.line_total !== want.line_total) begin
                  $error("line_total: expected %0d, actual %0d",
                         want.line_total, got.line_total);
                  failures++;
               end
               if (got.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0d, actual %0d", want.last_byte, got.last_byte);
                  failures++;
               end
               bytes_checked++;
               if (want.last_byte) lines_checked++;
            end
         end
      end
   end

   // Request driver: a request stays on the port until it is taken.
   always @(negedge clock) begin
      logic    next_valid;
      req_type next_payload;
      next_valid = req_valid;
      next_payload = req_payload;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_taken) next_valid = 1'b0;
         if (!next_valid && pending_bytes.size() != 0 &&
             $urandom_range(99) >= req_idle_pct) begin
            next_payload = pending_bytes.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_payload <= next_payload;
   end

   // Result side back-pressure, with an occasional long hold-off.
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= !reset && (hold_left > 0 || $urandom_range(99) < rsp_idle_pct);
   end

   task automatic push_byte(int unsigned ch, logic [BYTE_W-1:0] value);
      req_type r;
      r.channel = CH_W'(ch);
      r.data_byte = value;
      pending_bytes.push_back(r);
      requests_queued++;
   endtask

   function automatic logic [BYTE_W-1:0] random_text_byte();
      logic [BYTE_W-1:0] value;
      do value = BYTE_W'($urandom_range(255));
      while (value == CHAR_CR || value == CHAR_LF);
      return value;
   endfunction

   // A line of random text bytes closed by CR or LF.
   task automatic push_line(int unsigned ch, int unsigned len);
      for (int i = 0; i < len; i++) push_byte(ch, random_text_byte());
      push_byte(ch, $urandom_range(1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic push_random_traffic(int unsigned count);
      int unsigned start;
      int unsigned pick;
      start = requests_queued;
      while (requests_queued - start < count) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            push_line($urandom_range(CHANNELS - 1), $urandom_range(1, 8));
         end else if (pick < 75) begin
            push_line($urandom_range(CHANNELS - 1), $urandom_range(9, 24));
         end else if ($urandom_range(99) < 20) begin
            push_byte($urandom_range(CHANNELS - 1), $urandom_range(1) ? CHAR_CR : CHAR_LF);
         end else begin
            push_byte($urandom_range(CHANNELS - 1), BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (requests_accepted != requests_queued || expected_line_bytes.size() != 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 6;
      rsp_idle_pct = 70;
      // Line ends on empty channels release nothing.
      push_byte(0, CHAR_CR);
      push_byte(1, CHAR_LF);
      // Two channels filled in turn: channel 0 with the byte extremes, channel 1 with 8'hAA and 8'h55.
      push_byte(0, 8'h00);
      push_byte(1, 8'hAA);
      push_byte(0, 8'hFF);
      push_byte(1, 8'h55);
      push_byte(0, CHAR_CR);
      push_byte(1, CHAR_LF);
      // One-byte line, then CR LF where the LF finds an empty line.
      push_byte(1, 8'h01);
      push_byte(1, CHAR_CR);
      push_byte(0, 8'h7F);
      push_byte(0, 8'h80);
      push_byte(0, CHAR_CR);
      push_byte(0, CHAR_LF);
      push_random_traffic(6);
      wait_drained();

      req_idle_pct = 70;
      rsp_idle_pct = 6;
      push_random_traffic(4);
      // Overflowing line: dropped, the rest ignored until the line end, then a clean line.
      push_line(0, LINE_MAX + 1);
      push_line(0, 2);
      wait_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // A full line under a long hold-off, with more requests queued behind it.
      holds_asked++;
      push_line(1, LINE_MAX);
      push_line(0, 2);
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Offered %0d requests on both channels, through empty, full and overflowing lines",
               requests_accepted);
      $display("under three back-pressure mixes; %0d line bytes in %0d lines compared.",
               bytes_checked, lines_checked);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
